FILE: sv/irlcr_pkg.sv
// Shared types and constants for the learned IR code replay block.
package irlcr_pkg;

  localparam int MAX_SEGMENTS     = 128;
  localparam int PULSE_TABLE_SIZE = 3;
  localparam int CODE_W           = 80;
  localparam int COUNT_W          = 7;
  localparam int WIDTH_W          = 8;
  localparam int SYM_CAP_INT      = (MAX_SEGMENTS - 2 > 127) ? 127 : MAX_SEGMENTS - 2;
  localparam logic [COUNT_W-1:0] SYM_CAP = COUNT_W'(SYM_CAP_INT);
  localparam logic [WIDTH_W-1:0] WIDTH_UNUSED = 8'hFF;

  // configuration register indexes
  localparam logic [2:0] REG_PULSE_WIDTH_0 = 3'd0;
  localparam logic [2:0] REG_PULSE_WIDTH_1 = 3'd1;
  localparam logic [2:0] REG_PULSE_WIDTH_2 = 3'd2;
  localparam logic [2:0] REG_HEADER_MARK   = 3'd3;
  localparam logic [2:0] REG_HEADER_SPACE  = 3'd4;

  // input selector codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // header stage codes
  localparam logic [1:0] STAGE_MARK    = 2'd0;
  localparam logic [1:0] STAGE_SPACE   = 2'd1;
  localparam logic [1:0] STAGE_SYMBOLS = 2'd2;

  typedef struct packed {
    logic [2:0][WIDTH_W-1:0] pulse_width;
    logic [WIDTH_W-1:0]      header_mark;
    logic [WIDTH_W-1:0]      header_space;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic               is_start;
    logic               reject;
    logic               three_mode;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SKIP
  } bk_state_t;

endpackage

FILE: sv/irlcr_front.sv
// Front end: configuration registers, input classification and start decode.
module irlcr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [87:0]           s_tdata,
  input  logic                  s_tuser,
  input  logic                  q_full,
  output logic                  q_push,
  output irlcr_pkg::q_entry_t   q_wdata,
  output irlcr_pkg::cfg_t       cfg
);

  logic [1:0]                        valid_cnt;
  logic                              still_valid;
  logic [irlcr_pkg::COUNT_W-1:0]     count_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_width  <= {3{irlcr_pkg::WIDTH_UNUSED}};
      cfg.header_mark  <= '0;
      cfg.header_space <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        irlcr_pkg::REG_PULSE_WIDTH_0: cfg.pulse_width[0] <= cfg_data;
        irlcr_pkg::REG_PULSE_WIDTH_1: cfg.pulse_width[1] <= cfg_data;
        irlcr_pkg::REG_PULSE_WIDTH_2: cfg.pulse_width[2] <= cfg_data;
        irlcr_pkg::REG_HEADER_MARK:   cfg.header_mark    <= cfg_data;
        irlcr_pkg::REG_HEADER_SPACE:  cfg.header_space   <= cfg_data;
        default: ;
      endcase
    end
  end

  // count widths up to the first unused one
  always_comb begin
    valid_cnt   = 2'd0;
    still_valid = 1'b1;
    for (int i = 0; i < irlcr_pkg::PULSE_TABLE_SIZE; i++) begin
      if (cfg.pulse_width[i] == irlcr_pkg::WIDTH_UNUSED) still_valid = 1'b0;
      if (still_valid) valid_cnt = valid_cnt + 2'd1;
    end
  end

  assign count_in = s_tdata[86:80];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_wdata.is_start   = (s_tuser == irlcr_pkg::FUNC_START);
    q_wdata.reject     = (valid_cnt != 2'd2) && (valid_cnt != 2'd3);
    q_wdata.three_mode = (valid_cnt == 2'd3);
    q_wdata.code       = s_tdata[79:0];
    q_wdata.count      = (count_in > irlcr_pkg::SYM_CAP) ? irlcr_pkg::SYM_CAP : count_in;
  end

endmodule

FILE: sv/irlcr_fifo.sv
// Two-entry queue between the front end and the replay engine.
module irlcr_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  irlcr_pkg::q_entry_t wdata,
  input  logic                pop,
  output irlcr_pkg::q_entry_t rdata,
  output logic                full,
  output logic                empty
);

  irlcr_pkg::q_entry_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wdata;
  end

  assign rdata = entries[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

endmodule

FILE: sv/irlcr_back.sv
// Replay engine: burst state, segment walk and result register.
module irlcr_back (
  input  logic                clk,
  input  logic                rst,
  input  irlcr_pkg::cfg_t     cfg,
  input  logic                q_empty,
  input  irlcr_pkg::q_entry_t q_rdata,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);

  irlcr_pkg::bk_state_t state, state_next;

  logic [irlcr_pkg::CODE_W-1:0]  code_shift, code_shift_next;
  logic [irlcr_pkg::COUNT_W-1:0] symbols_left, symbols_left_next;
  logic [irlcr_pkg::WIDTH_W-1:0] ticks_left, ticks_left_next;
  logic [1:0] header_stage, header_stage_next;
  logic level_on, level_on_next;
  logic active, active_next;
  logic three_mode, three_mode_next;
  logic tx_hold, tx_hold_next;
  logic is_tick, is_tick_next;

  logic       out_valid;
  logic [3:0] out_bits, out_bits_next;   // {done, rejected, busy, tx}
  logic       out_write;
  logic       slot_free;

  logic [1:0]                    sym;
  logic                          shift_two;
  logic [irlcr_pkg::WIDTH_W-1:0] sym_width;

  // prefix decode at the head of the code stream
  always_comb begin
    if (!code_shift[0]) begin
      sym = 2'd0;
      shift_two = 1'b0;
    end else if (!three_mode) begin
      sym = 2'd1;
      shift_two = 1'b0;
    end else if (!code_shift[1]) begin
      sym = 2'd1;
      shift_two = 1'b1;
    end else begin
      sym = 2'd2;
      shift_two = 1'b1;
    end
    sym_width = cfg.pulse_width[sym];
  end

  assign slot_free = !out_valid || m_tready;

  always_comb begin
    state_next        = state;
    code_shift_next   = code_shift;
    symbols_left_next = symbols_left;
    ticks_left_next   = ticks_left;
    header_stage_next = header_stage;
    level_on_next     = level_on;
    active_next       = active;
    three_mode_next   = three_mode;
    tx_hold_next      = tx_hold;
    is_tick_next      = is_tick;
    out_write         = 1'b0;
    out_bits_next     = 4'd0;
    q_pop             = 1'b0;

    case (state)
      irlcr_pkg::BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          if (q_rdata.is_start) begin
            if (q_rdata.reject) begin
              out_write     = 1'b1;
              out_bits_next = {1'b0, 1'b1, active, 1'b0};
            end else begin
              code_shift_next   = q_rdata.code;
              symbols_left_next = q_rdata.count;
              header_stage_next = irlcr_pkg::STAGE_MARK;
              ticks_left_next   = cfg.header_mark;
              level_on_next     = 1'b1;
              active_next       = 1'b1;
              three_mode_next   = q_rdata.three_mode;
              tx_hold_next      = 1'b0;
              is_tick_next      = 1'b0;
              state_next        = irlcr_pkg::BK_SKIP;
            end
          end else if (!active) begin
            out_write     = 1'b1;
            out_bits_next = 4'd0;
          end else begin
            tx_hold_next    = level_on;
            ticks_left_next = ticks_left - 8'd1;
            is_tick_next    = 1'b1;
            state_next      = irlcr_pkg::BK_SKIP;
          end
        end
      end
      irlcr_pkg::BK_SKIP: begin
        // walk one finished segment per cycle
        if (active && ticks_left == '0) begin
          if (header_stage == irlcr_pkg::STAGE_MARK) begin
            header_stage_next = irlcr_pkg::STAGE_SPACE;
            ticks_left_next   = cfg.header_space;
            level_on_next     = 1'b0;
          end else if (symbols_left == '0) begin
            active_next   = 1'b0;
            level_on_next = 1'b0;
          end else begin
            header_stage_next = irlcr_pkg::STAGE_SYMBOLS;
            symbols_left_next = symbols_left - 7'd1;
            ticks_left_next   = sym_width;
            level_on_next     = !level_on;
            code_shift_next   = shift_two ? {2'b00, code_shift[irlcr_pkg::CODE_W-1:2]}
                                          : {1'b0, code_shift[irlcr_pkg::CODE_W-1:1]};
          end
        end else begin
          out_write     = 1'b1;
          out_bits_next = {is_tick && !active, 1'b0, active, tx_hold};
          state_next    = irlcr_pkg::BK_IDLE;
        end
      end
      default: state_next = irlcr_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= irlcr_pkg::BK_IDLE;
      active    <= 1'b0;
      level_on  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      active   <= active_next;
      level_on <= level_on_next;
      if (out_write)     out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    code_shift   <= code_shift_next;
    symbols_left <= symbols_left_next;
    ticks_left   <= ticks_left_next;
    header_stage <= header_stage_next;
    three_mode   <= three_mode_next;
    tx_hold      <= tx_hold_next;
    is_tick      <= is_tick_next;
    if (out_write) out_bits <= out_bits_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_bits[2:0]};
  assign m_tlast  = out_bits[3];

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_write |-> slot_free)
    else $error("result register overwritten");

  // between items an active burst always has ticks left in its segment
  a_idle_has_ticks: assert property (@(posedge clk) disable iff (rst)
    (state == irlcr_pkg::BK_IDLE && active) |-> ticks_left != '0)
    else $error("idle with empty active segment");

  // the end of a burst is never reported while still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_write |-> !(out_bits_next[3] && out_bits_next[1]))
    else $error("done reported while busy");

  // a refused start never drives the envelope on
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    out_write |-> !(out_bits_next[2] && out_bits_next[0]))
    else $error("rejected start with envelope on");

  // nothing is taken from the queue while a segment walk is running
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == irlcr_pkg::BK_IDLE && !q_empty))
    else $error("queue read outside idle");

endmodule

FILE: sv/ir_learned_code_replay_top.sv
// Top level of the learned IR code replay block.
//
// channel   dir  handshake          payload
// s_        in   tvalid/tready      tdata: code_low, code_high, symbol_count; tuser: func
// m_        out  tvalid/tready      tdata: tx_on, busy_res, rejected; tlast: done_res
// cfg_      in   we                 index, data (8 bits)
//
// A rejected start and a tick on an idle block are answered straight from the idle state.
// A start or a tick on an active burst goes on to the segment walk in the engine, which
// steps past each finished segment before the result is written.
// The front end takes items into a two-entry queue while the engine works.
// Reset (rst, synchronous) restores the register defaults and empties the burst.
// m_tready low holds the result; the engine then waits and the queue fills.
module ir_learned_code_replay_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // code_low [63:0], code_high [79:64], symbol_count [86:80]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // tx_on [0], busy_res [1], rejected [2]
  output logic        m_tlast    // done_res
);

  irlcr_pkg::cfg_t     cfg;
  irlcr_pkg::q_entry_t q_wdata;
  irlcr_pkg::q_entry_t q_rdata;
  logic q_push, q_pop, q_full, q_empty;

  irlcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .cfg       (cfg)
  );

  irlcr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  irlcr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
